>>> src/bitvector_interval_accumulator_top_macros.svh
// Assertion macros shared by the RTL. Each expands to one labeled assertion
// clocked on clk and disabled while rst_n is low.
`ifndef BITVECTOR_INTERVAL_ACCUMULATOR_TOP_MACROS_SVH
`define BITVECTOR_INTERVAL_ACCUMULATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bia_pkg.sv
package bia_pkg;

  localparam int DATA_W      = 64;
  localparam int FUNC_W      = 3;
  localparam int CNT_W       = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_BITS_DEF = 64;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MAC  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FULL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

  localparam logic [CNT_W-1:0] BIT_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] operand_low;
    logic [DATA_W-1:0] operand_high;
    logic [DATA_W-1:0] coeff;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_low;
    logic [DATA_W-1:0] result_high;
    logic              widened;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] bit_count;
    logic             signed_mode;
  } cfg_t;

endpackage

>>> src/bia_core.sv
module bia_core #(
  parameter int W = bia_pkg::MAX_BITS_DEF
) (
  input  bia_pkg::cfg_t             cfg,
  input  logic [bia_pkg::FUNC_W-1:0] func,
  input  logic [W-1:0]              op_lo,
  input  logic [W-1:0]              op_hi,
  input  logic [W-1:0]              coeff,
  input  logic [W-1:0]              st_lo_raw,
  input  logic [W-1:0]              st_hi_raw,
  output logic [W-1:0]              lo_nxt,
  output logic [W-1:0]              hi_nxt,
  output logic                      wide
);

  localparam logic [bia_pkg::CNT_W-1:0] MAX_N = bia_pkg::CNT_W'(W);

  logic [bia_pkg::CNT_W-1:0] nb;
  logic [W-1:0] mask, sbit;
  logic [W-1:0] l, u, c, sl, sh;
  logic [W-1:0] fr_lo, fr_hi;
  logic [W-1:0] add_lo, add_hi, sub_lo, sub_hi;
  logic [W-1:0] sflip;
  logic         op_ok, st_ok;
  logic         s_sl, s_sh, s_l, s_u, s_al, s_ah, s_bl, s_bh;
  logic         add_wide, sub_wide, add_sel, sub_sel;

  always_comb begin
    if (cfg.bit_count == '0) begin
      nb = bia_pkg::CNT_W'(1);
    end else if (cfg.bit_count > MAX_N) begin
      nb = MAX_N;
    end else begin
      nb = cfg.bit_count;
    end
    for (int i = 0; i < W; i++) begin
      mask[i] = bia_pkg::CNT_W'(i) < nb;
      sbit[i] = bia_pkg::CNT_W'(i) == (nb - bia_pkg::CNT_W'(1));
    end
  end

  assign l  = op_lo & mask;
  assign u  = op_hi & mask;
  assign c  = coeff & mask;
  assign sl = st_lo_raw & mask;
  assign sh = st_hi_raw & mask;

  // In signed mode, flipping the sign bit turns the order into an unsigned one.
  assign sflip = cfg.signed_mode ? sbit : '0;
  assign op_ok = (l ^ sflip) <= (u ^ sflip);
  assign st_ok = (sl ^ sflip) <= (sh ^ sflip);

  assign fr_lo = cfg.signed_mode ? sbit : '0;
  assign fr_hi = cfg.signed_mode ? (mask & ~sbit) : mask;

  assign add_lo = (sl + l) & mask;
  assign add_hi = (sh + u) & mask;
  assign sub_lo = (sl - u) & mask;
  assign sub_hi = (sh - l) & mask;

  assign s_sl = |(sl & sbit);
  assign s_sh = |(sh & sbit);
  assign s_l  = |(l & sbit);
  assign s_u  = |(u & sbit);
  assign s_al = |(add_lo & sbit);
  assign s_ah = |(add_hi & sbit);
  assign s_bl = |(sub_lo & sbit);
  assign s_bh = |(sub_hi & sbit);

  always_comb begin
    if (cfg.signed_mode) begin
      add_wide = ((s_sl && s_l && !s_al) && !(s_sh && s_u && !s_ah)) ||
                 ((!s_sh && !s_u && s_ah) && !(!s_sl && !s_l && s_al));
      sub_wide = ((s_sl && !s_u && !s_bl) && !(s_sh && !s_l && !s_bh)) ||
                 ((!s_sh && s_l && s_bh) && !(!s_sl && s_u && s_bl));
    end else begin
      add_wide = (add_hi < u) && !(add_lo < l);
      sub_wide = (sl < u) && (sh >= l);
    end
  end

  assign add_sel = (func == bia_pkg::FUNC_ADD) ||
                   ((func == bia_pkg::FUNC_MAC) && (c == W'(1)));
  assign sub_sel = (func == bia_pkg::FUNC_SUB) || (c == mask);

  always_comb begin
    lo_nxt = sl;
    hi_nxt = sh;
    wide   = 1'b0;
    unique case (func)
      bia_pkg::FUNC_LOAD: begin
        if (op_ok) begin
          lo_nxt = l;
          hi_nxt = u;
        end else begin
          wide = 1'b1;
        end
      end
      bia_pkg::FUNC_ADD, bia_pkg::FUNC_SUB, bia_pkg::FUNC_MAC: begin
        priority if (!op_ok || !st_ok) begin
          wide = 1'b1;
        end else if (add_sel) begin
          wide   = add_wide;
          lo_nxt = add_lo;
          hi_nxt = add_hi;
        end else if (sub_sel) begin
          wide   = sub_wide;
          lo_nxt = sub_lo;
          hi_nxt = sub_hi;
        end else begin
          wide = 1'b1;
        end
      end
      bia_pkg::FUNC_FULL: begin
        lo_nxt = fr_lo;
        hi_nxt = fr_hi;
      end
      default: begin
      end
    endcase
    if (wide) begin
      lo_nxt = fr_lo;
      hi_nxt = fr_hi;
    end
  end

endmodule

>>> src/bitvector_interval_accumulator_top.sv
// An accepted item waits in the input register; its result is loaded into
// the output register when out_ready is high or the output is empty.
// Throughput: one item per cycle unless the output stalls; combinational update.
// Reset (rst_n low, synchronous) empties both registers, sets the interval
// to [0, 0], bit_count to 64 and signed_mode to 0.
`include "bitvector_interval_accumulator_top_macros.svh"

module bitvector_interval_accumulator_top #(
  parameter int MAX_BITS = bia_pkg::MAX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bia_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bia_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bia_pkg::CFG_DATA_W-1:0] cfg_data
);

  bia_pkg::cfg_t cfg_r;
  bia_pkg::in_t  in_data_r;
  bia_pkg::out_t out_data_r;
  logic          in_valid_r, out_valid_r;
  logic [MAX_BITS-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic          wide;
  logic          advance, fire;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  bia_core #(
    .W(MAX_BITS)
  ) u_core (
    .cfg       (cfg_r),
    .func      (in_data_r.func),
    .op_lo     (in_data_r.operand_low[MAX_BITS-1:0]),
    .op_hi     (in_data_r.operand_high[MAX_BITS-1:0]),
    .coeff     (in_data_r.coeff[MAX_BITS-1:0]),
    .st_lo_raw (lo_r),
    .st_hi_raw (hi_r),
    .lo_nxt    (lo_nxt),
    .hi_nxt    (hi_nxt),
    .wide      (wide)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_count   <= bia_pkg::BIT_COUNT_RST;
      cfg_r.signed_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bia_pkg::REG_BIT_COUNT:   cfg_r.bit_count   <= cfg_data;
        bia_pkg::REG_SIGNED_MODE: cfg_r.signed_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        lo_r <= lo_nxt;
        hi_r <= hi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r.result_low  <= bia_pkg::DATA_W'(lo_nxt);
      out_data_r.result_high <= bia_pkg::DATA_W'(hi_nxt);
      out_data_r.widened     <= wide;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BIA_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_r, "item processed without a result")
  `BIA_ASSERT_SAME(a_result_matches_state, out_valid_r, (out_data_r.result_low == bia_pkg::DATA_W'(lo_r)) && (out_data_r.result_high == bia_pkg::DATA_W'(hi_r)), "pending result differs from stored interval")
  `BIA_ASSERT_NEXT(a_held_item_kept, in_valid_r && !advance, in_valid_r && $stable(in_data_r), "stalled item lost or changed")

endmodule

>>> verif/bitvector_interval_accumulator_top_tb.sv
module bitvector_interval_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bia_pkg::FUNC_W-1:0] FUNC_RSVD_LO = 3'd5;
  localparam logic [bia_pkg::FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;
  localparam bit [bia_pkg::DATA_W-1:0] ALL_ONES = '1;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  bia_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_ready;
  bia_pkg::out_t                  out_data;
  logic                           cfg_we;
  logic [bia_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bia_pkg::CFG_DATA_W-1:0] cfg_data;

  bit [bia_pkg::CNT_W-1:0]  model_bits = bia_pkg::BIT_COUNT_RST;
  bit                       model_signed = 1'b0;
  bit [bia_pkg::DATA_W-1:0] acc_low = '0;
  bit [bia_pkg::DATA_W-1:0] acc_high = '0;
  bia_pkg::out_t            pending_intervals[$];
  int                       err_count = 0;
  bit                       no_idle = 1'b0;

  bitvector_interval_accumulator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[bitvector_interval_accumulator_top] ERROR");
    $finish;
  end

  function automatic bit [bia_pkg::DATA_W-1:0] width_mask();
    int n;
    n = int'(model_bits);
    if (n < 1) n = 1;
    if (n > bia_pkg::DATA_W) n = bia_pkg::DATA_W;
    return (n == bia_pkg::DATA_W) ? ALL_ONES : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic bit [bia_pkg::DATA_W-1:0] sign_bit();
    return (width_mask() >> 1) + 64'd1;
  endfunction

  function automatic bit ordered(bit [bia_pkg::DATA_W-1:0] x, bit [bia_pkg::DATA_W-1:0] y);
    bit [bia_pkg::DATA_W-1:0] flip;
    flip = model_signed ? sign_bit() : '0;
    return (x ^ flip) <= (y ^ flip);
  endfunction

  // Advances the interval by one item and returns the result it must produce.
  function automatic bia_pkg::out_t next_interval(bia_pkg::in_t it);
    bit [bia_pkg::DATA_W-1:0] mask, sb, l, u, c, nl, nh;
    bit op_ok, st_ok, wide, add_op, sub_op;
    bit sl, sh, bl, bu, rl, rh;
    bia_pkg::out_t r;
    mask = width_mask();
    sb = sign_bit();
    l = it.operand_low & mask;
    u = it.operand_high & mask;
    c = it.coeff & mask;
    acc_low &= mask;
    acc_high &= mask;
    op_ok = ordered(l, u);
    st_ok = ordered(acc_low, acc_high);
    wide = 1'b0;
    add_op = 1'b0;
    sub_op = 1'b0;
    nl = '0;
    nh = '0;
    case (it.func)
      bia_pkg::FUNC_LOAD: begin
        if (op_ok) begin
          acc_low = l;
          acc_high = u;
        end else begin
          wide = 1'b1;
        end
      end
      bia_pkg::FUNC_ADD, bia_pkg::FUNC_SUB, bia_pkg::FUNC_MAC: begin
        if (!op_ok || !st_ok) wide = 1'b1;
        else if (it.func == bia_pkg::FUNC_ADD || (it.func == bia_pkg::FUNC_MAC && c == 64'd1))
          add_op = 1'b1;
        else if (it.func == bia_pkg::FUNC_SUB || c == mask) sub_op = 1'b1;
        else wide = 1'b1;
      end
      default: ;
    endcase
    if (add_op) begin
      nl = (acc_low + l) & mask;
      nh = (acc_high + u) & mask;
    end
    if (sub_op) begin
      nl = (acc_low - u) & mask;
      nh = (acc_high - l) & mask;
    end
    sl = |(acc_low & sb);
    sh = |(acc_high & sb);
    bl = |(l & sb);
    bu = |(u & sb);
    rl = |(nl & sb);
    rh = |(nh & sb);
    // Only one end wrapping forces the full range; both wrapping keeps the ends.
    if (add_op) begin
      if (model_signed) begin
        wide = (sl && bl && !rl && !(sh && bu && !rh)) ||
               (!sh && !bu && rh && !(!sl && !bl && rl));
      end else begin
        wide = (nh < u) && !(nl < l);
      end
    end
    if (sub_op) begin
      if (model_signed) begin
        wide = (sl && !bu && !rl && !(sh && !bl && !rh)) ||
               (!sh && bl && rh && !(!sl && bu && rl));
      end else begin
        wide = (acc_low < u) && (acc_high >= l);
      end
    end
    if ((add_op || sub_op) && !wide) begin
      acc_low = nl;
      acc_high = nh;
    end
    if (wide || it.func == bia_pkg::FUNC_FULL) begin
      acc_low = model_signed ? sb : '0;
      acc_high = model_signed ? ((sb - 64'd1) & mask) : mask;
    end
    r.result_low = acc_low;
    r.result_high = acc_high;
    r.widened = wide;
    return r;
  endfunction

  function automatic bit [bia_pkg::DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Interval ends biased toward the corners of the current width and mode.
  function automatic bit [bia_pkg::DATA_W-1:0] pick_end();
    bit [bia_pkg::DATA_W-1:0] mask, sb, v;
    mask = width_mask();
    sb = sign_bit();
    case ($urandom_range(0, 8))
      0: v = '0;
      1: v = 64'd1;
      2: v = mask;
      3: v = sb;
      4: v = sb - 64'd1;
      5: v = 64'($urandom_range(0, 15));
      6: v = mask - 64'($urandom_range(0, 15));
      7: v = sb + 64'($urandom_range(0, 15));
      default: v = rand_word();
    endcase
    v &= mask;
    if ($urandom_range(0, 3) == 0) v |= rand_word() & ~mask;
    return v;
  endfunction

  function automatic bia_pkg::in_t make_item();
    bia_pkg::in_t it;
    bit [bia_pkg::DATA_W-1:0] a, b, mask;
    int sel;
    mask = width_mask();
    sel = $urandom_range(0, 99);
    if (sel < 20) it.func = bia_pkg::FUNC_LOAD;
    else if (sel < 45) it.func = bia_pkg::FUNC_ADD;
    else if (sel < 65) it.func = bia_pkg::FUNC_SUB;
    else if (sel < 88) it.func = bia_pkg::FUNC_MAC;
    else if (sel < 94) it.func = bia_pkg::FUNC_FULL;
    else it.func = bia_pkg::FUNC_W'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
    a = pick_end();
    b = $urandom_range(0, 1) ? a + 64'($urandom_range(0, 15)) : pick_end();
    // Most operands are well ordered so that the interval keeps evolving.
    if ($urandom_range(0, 9) != 0 && !ordered(a & mask, b & mask)) begin
      it.operand_low = b;
      it.operand_high = a;
    end else begin
      it.operand_low = a;
      it.operand_high = b;
    end
    case ($urandom_range(0, 2))
      0: it.coeff = 64'd1;
      1: it.coeff = mask;
      default: it.coeff = rand_word();
    endcase
    if ($urandom_range(0, 2) == 0) it.coeff |= rand_word() & ~mask;
    return it;
  endfunction

  task automatic push_item(bia_pkg::in_t it);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (!in_ready);
    pending_intervals.push_back(next_interval(it));
    @(posedge clk);
  endtask

  task automatic send_op(logic [bia_pkg::FUNC_W-1:0] f, bit [bia_pkg::DATA_W-1:0] lo,
                         bit [bia_pkg::DATA_W-1:0] hi, bit [bia_pkg::DATA_W-1:0] c);
    bia_pkg::in_t it;
    it.func = f;
    it.operand_low = lo;
    it.operand_high = hi;
    it.coeff = c;
    push_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(bit [bia_pkg::CNT_W-1:0] bits, bit sgn);
    bit [bia_pkg::CFG_DATA_W-1:0] junk;
    junk = bia_pkg::CFG_DATA_W'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= bia_pkg::REG_BIT_COUNT;
    cfg_data <= bits;
    @(posedge clk);
    cfg_index <= bia_pkg::REG_SIGNED_MODE;
    cfg_data <= {junk[bia_pkg::CFG_DATA_W-1:1], sgn};
    @(posedge clk);
    cfg_we <= 1'b0;
    model_bits = bits;
    model_signed = sgn;
  endtask

  task automatic test_unsigned_cases();
    send_op(bia_pkg::FUNC_LOAD, 64'd5, 64'd10, '0);
    send_op(bia_pkg::FUNC_ADD, 64'd1, 64'd2, '0);
    send_op(bia_pkg::FUNC_SUB, 64'd1, 64'd2, '0);
    send_op(bia_pkg::FUNC_MAC, 64'd1, 64'd1, 64'd1);
    send_op(bia_pkg::FUNC_MAC, 64'd1, 64'd1, ALL_ONES);
    send_op(bia_pkg::FUNC_MAC, 64'd1, 64'd1, 64'd2);
    send_op(FUNC_RSVD_LO, ALL_ONES, '0, ALL_ONES);
    send_op(FUNC_RSVD_HI, '0, ALL_ONES, '0);
    send_op(bia_pkg::FUNC_LOAD, 64'd10, 64'd5, '0);
    send_op(bia_pkg::FUNC_LOAD, ALL_ONES - 64'd1, ALL_ONES, '0);
    send_op(bia_pkg::FUNC_ADD, 64'd0, 64'd1, '0);
    send_op(bia_pkg::FUNC_LOAD, ALL_ONES - 64'd1, ALL_ONES, '0);
    send_op(bia_pkg::FUNC_ADD, 64'd2, 64'd3, '0);
    send_op(bia_pkg::FUNC_FULL, '0, '0, '0);
  endtask

  task automatic test_signed_cases();
    wait_idle();
    set_config(7'd8, 1'b1);
    send_op(bia_pkg::FUNC_LOAD, 64'hA7E, 64'h37F, '0);
    send_op(bia_pkg::FUNC_ADD, 64'd1, 64'd1, '0);
    send_op(bia_pkg::FUNC_LOAD, 64'h7F, 64'h7F, '0);
    send_op(bia_pkg::FUNC_ADD, 64'd1, 64'd1, '0);
    send_op(bia_pkg::FUNC_SUB, 64'd1, 64'd1, '0);
  endtask

  task automatic test_config_carryover();
    wait_idle();
    set_config(7'd8, 1'b0);
    send_op(bia_pkg::FUNC_LOAD, 64'h10, 64'hF0, '0);
    wait_idle();
    set_config(7'd8, 1'b1);
    send_op(bia_pkg::FUNC_ADD, '0, '0, '0);
    wait_idle();
    set_config(7'd1, 1'b1);
    send_op(bia_pkg::FUNC_MAC, '0, '0, 64'd1);
    wait_idle();
    set_config(7'd0, 1'b0);
    send_op(bia_pkg::FUNC_ADD, 64'd1, 64'd1, '0);
    wait_idle();
    set_config(7'd127, 1'b1);
    send_op(bia_pkg::FUNC_LOAD, ALL_ONES, '0, '0);
    send_op(bia_pkg::FUNC_FULL, '0, '0, '0);
  endtask

  task automatic test_random_phase(bit [bia_pkg::CNT_W-1:0] bits, bit sgn, int count);
    wait_idle();
    set_config(bits, sgn);
    repeat (count) begin
      if (!no_idle && $urandom_range(0, 149) == 0) wait_idle();
      push_item(make_item());
    end
  endtask

  task automatic test_streaming();
    no_idle = 1'b1;
    test_random_phase(7'd64, 1'b1, 100);
    test_random_phase(7'd8, 1'b0, 60);
  endtask

  always @(negedge clk) begin
    bia_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_intervals.size() == 0) begin
        err_count++;
        $display("%0t: result with no item pending: expected none actual %h", $time, out_data);
      end else begin
        want = pending_intervals.pop_front();
        if (out_data.result_low !== want.result_low) begin
          err_count++;
          $display("%0t: result_low expected %h actual %h", $time, want.result_low,
                   out_data.result_low);
        end
        if (out_data.result_high !== want.result_high) begin
          err_count++;
          $display("%0t: result_high expected %h actual %h", $time, want.result_high,
                   out_data.result_high);
        end
        if (out_data.widened !== want.widened) begin
          err_count++;
          $display("%0t: widened expected %b actual %b", $time, want.widened,
                   out_data.widened);
        end
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    bit [bia_pkg::CNT_W-1:0] phase_bits[15];
    bit                      phase_sign[15];
    phase_bits = '{7'd64, 7'd64, 7'd8, 7'd8, 7'd1, 7'd1, 7'd2, 7'd63, 7'd0, 7'd127,
                   7'd65, 7'd16, 7'd33, 7'd1, 7'd1};
    phase_sign = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                   1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_bits[13] = bia_pkg::CNT_W'($urandom_range(1, 64));
    phase_bits[14] = bia_pkg::CNT_W'($urandom_range(1, 64));
    phase_sign[13] = 1'($urandom_range(0, 1));
    phase_sign[14] = 1'($urandom_range(0, 1));
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= bia_pkg::REG_BIT_COUNT;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_unsigned_cases();
    test_signed_cases();
    test_config_carryover();
    for (int i = 0; i < 15; i++) test_random_phase(phase_bits[i], phase_sign[i], 110);
    test_streaming();
    wait_idle();
    if (err_count == 0) begin
      $display("[bitvector_interval_accumulator_top] OK");
    end else begin
      $display("[bitvector_interval_accumulator_top] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/bia_pkg.sv
src/bia_core.sv
src/bitvector_interval_accumulator_top.sv
verif/bitvector_interval_accumulator_top_tb.sv
